// ===== sv/tsmb_pkg.sv =====
package tsmb_pkg;

  localparam int unsigned ADDR_BITS  = 24;
  localparam int unsigned WIDTH_BITS = 12;
  localparam int unsigned COL_BITS   = 11;
  localparam int unsigned LINE_BITS  = 15;
  localparam int unsigned PADDR_BITS = 5;

  localparam logic [WIDTH_BITS-1:0] MAX_WIDTH  = 12'd2048;
  localparam logic [15:0]           MAX_HEIGHT = 16'd32768;

  // Input operation codes.
  localparam logic OP_START = 1'b0;
  localparam logic OP_WORD  = 1'b1;

  // Register indexes (byte address is four times the index).
  localparam logic [2:0] REG_CONTROL_ZERO    = 3'd0;
  localparam logic [2:0] REG_CONTROL_ONE     = 3'd1;
  localparam logic [2:0] REG_FIRST_WORD_MASK = 3'd2;
  localparam logic [2:0] REG_LAST_WORD_MASK  = 3'd3;
  localparam logic [2:0] REG_WIDTH_WORDS     = 3'd4;
  localparam logic [2:0] REG_HEIGHT_LINES    = 3'd5;
  localparam logic [2:0] REG_DEST_START      = 3'd6;
  localparam logic [2:0] REG_DEST_MODULO     = 3'd7;

  typedef struct packed {
    logic        operation;
    logic [15:0] a_word;
    logic [15:0] b_word;
    logic [15:0] c_word;
  } src_word_t;

  typedef struct packed {
    logic [15:0]          d_word;
    logic [ADDR_BITS-1:0] d_address;
    logic                 d_write;
    logic                 line_end;
    logic                 blit_done;
  } dst_word_t;

  // Per-word control handed to the word unit.
  typedef struct packed {
    logic        use_a;
    logic        use_b;
    logic        use_c;
    logic        descending;
    logic [3:0]  a_shift;
    logic [3:0]  b_shift;
    logic [7:0]  minterm;
    logic        first_col;
    logic        last_col;
    logic [15:0] first_mask;
    logic [15:0] last_mask;
  } word_ctrl_t;

endpackage

// ===== sv/tsmb_word_unit.sv =====
module tsmb_word_unit
  import tsmb_pkg::*;
(
  input  word_ctrl_t  ctrl,
  input  logic [15:0] a_hold,
  input  logic [15:0] b_hold,
  input  src_word_t   src,
  output logic [15:0] a_new,
  output logic [15:0] b_new,
  output logic [15:0] d_word
);

  // Ascending shifts right through the hold word; descending shifts left.
  function automatic logic [15:0] barrel(input logic [15:0] hold, input logic [15:0] now,
                                         input logic [3:0] sh, input logic desc);
    logic [31:0] wide;
    begin
      if (desc) begin
        wide = {now, hold} << sh;
        barrel = wide[31:16];
      end else begin
        wide = {hold, now} >> sh;
        barrel = wide[15:0];
      end
    end
  endfunction

  logic [15:0] mask;
  logic [15:0] a_dat;
  logic [15:0] b_dat;
  logic [15:0] c_dat;

  always_comb begin
    mask = 16'hFFFF;
    if (ctrl.first_col) begin
      mask = mask & ctrl.first_mask;
    end
    if (ctrl.last_col) begin
      mask = mask & ctrl.last_mask;
    end
    a_new = (ctrl.use_a ? src.a_word : 16'hFFFF) & mask;
    b_new = ctrl.use_b ? src.b_word : 16'h0000;
    c_dat = ctrl.use_c ? src.c_word : 16'h0000;
    a_dat = barrel(a_hold, a_new, ctrl.a_shift, ctrl.descending);
    b_dat = barrel(b_hold, b_new, ctrl.b_shift, ctrl.descending);
    for (int i = 0; i < 16; i++) begin
      d_word[i] = ctrl.minterm[{a_dat[i], b_dat[i], c_dat[i]}];
    end
  end

endmodule

// ===== sv/three_source_minterm_blitter_core.sv =====
// Destination side of a three-source minterm blitter.
// Software programs the eight registers over the APB-style port while the
// block is idle, then sends a start word (operation 0) on the source channel,
// followed by one data word per destination word carrying the fetched A, B
// and C words. A start word yields nothing; each data word of a running blit
// yields one result word on the destination channel with the minterm result,
// its byte address, the write enable and the line and blit end flags. Data
// words that arrive while no blit runs are dropped.
// The result word is registered at the edge that takes the source word.
// Throughput is one word per cycle, set by the single output register; a new
// source word is taken whenever that register is empty or is being emptied in
// the same cycle. When the receiver stalls, the result holds and the source
// channel stalls with it.
// Reset clears the blit state (idle, pointer and hold words zero), drops any
// pending result word, and returns the registers to their reset values.
module three_source_minterm_blitter_core
  import tsmb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  src_valid,
  output logic                  src_ready,
  input  src_word_t             src_word,
  output logic                  dst_valid,
  input  logic                  dst_ready,
  output dst_word_t             dst_word,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  // Configuration registers.
  logic [15:0]           control_zero;
  logic [15:0]           control_one;
  logic [15:0]           first_word_mask;
  logic [15:0]           last_word_mask;
  logic [WIDTH_BITS-1:0] width_words;
  logic [15:0]           height_lines;
  logic [ADDR_BITS-1:0]  dest_start;
  logic [15:0]           dest_modulo;

  // Blit state.
  logic [15:0]           a_hold;
  logic [15:0]           b_hold;
  logic [COL_BITS-1:0]   column;
  logic [LINE_BITS-1:0]  line;
  logic [ADDR_BITS-1:0]  dest_pointer;
  logic                  active;

  logic [2:0] reg_index;
  logic       reg_write;

  assign pready    = 1'b1;
  assign reg_index = paddr[PADDR_BITS-1:2];
  assign reg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      control_zero    <= 16'h0000;
      control_one     <= 16'h0000;
      first_word_mask <= 16'hFFFF;
      last_word_mask  <= 16'hFFFF;
      width_words     <= 12'd1;
      height_lines    <= 16'd1;
      dest_start      <= '0;
      dest_modulo     <= 16'h0000;
    end else if (reg_write) begin
      case (reg_index)
        REG_CONTROL_ZERO:    control_zero    <= pwdata[15:0];
        REG_CONTROL_ONE:     control_one     <= pwdata[15:0];
        REG_FIRST_WORD_MASK: first_word_mask <= pwdata[15:0];
        REG_LAST_WORD_MASK:  last_word_mask  <= pwdata[15:0];
        REG_WIDTH_WORDS:     width_words     <= pwdata[WIDTH_BITS-1:0];
        REG_HEIGHT_LINES:    height_lines    <= pwdata[15:0];
        REG_DEST_START:      dest_start      <= pwdata[ADDR_BITS-1:0];
        REG_DEST_MODULO:     dest_modulo     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_CONTROL_ZERO:    prdata = {16'h0000, control_zero};
      REG_CONTROL_ONE:     prdata = {16'h0000, control_one};
      REG_FIRST_WORD_MASK: prdata = {16'h0000, first_word_mask};
      REG_LAST_WORD_MASK:  prdata = {16'h0000, last_word_mask};
      REG_WIDTH_WORDS:     prdata = {20'h00000, width_words};
      REG_HEIGHT_LINES:    prdata = {16'h0000, height_lines};
      REG_DEST_START:      prdata = {8'h00, dest_start};
      REG_DEST_MODULO:     prdata = {16'h0000, dest_modulo};
      default:             prdata = 32'h0000_0000;
    endcase
  end

  // Handshake: the output register is the only stage between the channels.
  logic src_take;
  logic take_start;
  logic take_data;

  assign src_ready  = !dst_valid || dst_ready;
  assign src_take   = src_valid && src_ready;
  assign take_start = src_take && (src_word.operation == OP_START);
  assign take_data  = src_take && (src_word.operation == OP_WORD) && active;

  // Position within the blit. A zero or oversized width or height counts as
  // the maximum.
  logic [WIDTH_BITS-1:0] width_eff;
  logic [15:0]           height_eff;
  logic [WIDTH_BITS-1:0] column_inc;
  logic [15:0]           line_inc;
  logic                  last_col;
  logic                  last_line;

  always_comb begin
    width_eff  = (width_words == '0 || width_words > MAX_WIDTH) ? MAX_WIDTH : width_words;
    height_eff = (height_lines == '0 || height_lines > MAX_HEIGHT) ? MAX_HEIGHT : height_lines;
    column_inc = {1'b0, column} + 12'd1;
    line_inc   = {1'b0, line} + 16'd1;
    last_col   = column_inc >= width_eff;
    last_line  = line_inc >= height_eff;
  end

  word_ctrl_t  ctrl;
  logic [15:0] a_new;
  logic [15:0] b_new;
  logic [15:0] d_word;
  logic        use_d;
  logic        descending;

  assign use_d      = control_zero[8];
  assign descending = control_one[1];

  always_comb begin
    ctrl.use_a      = control_zero[11];
    ctrl.use_b      = control_zero[10];
    ctrl.use_c      = control_zero[9];
    ctrl.descending = descending;
    ctrl.a_shift    = control_zero[15:12];
    ctrl.b_shift    = control_one[15:12];
    ctrl.minterm    = control_zero[7:0];
    ctrl.first_col  = (column == '0);
    ctrl.last_col   = last_col;
    ctrl.first_mask = first_word_mask;
    ctrl.last_mask  = last_word_mask;
  end

  tsmb_word_unit u_word_unit (
    .ctrl   (ctrl),
    .a_hold (a_hold),
    .b_hold (b_hold),
    .src    (src_word),
    .a_new  (a_new),
    .b_new  (b_new),
    .d_word (d_word)
  );

  // The destination pointer moves by one word, plus the sign-extended modulo
  // at a line end, downward in descending mode. It stays put when D is off.
  logic [ADDR_BITS-1:0] modulo_ext;
  logic [ADDR_BITS-1:0] step;
  logic [ADDR_BITS-1:0] dest_pointer_next;

  always_comb begin
    modulo_ext = {{(ADDR_BITS-16){dest_modulo[15]}}, dest_modulo};
    step       = last_col ? (ADDR_BITS'(2) + modulo_ext) : ADDR_BITS'(2);
    if (!use_d) begin
      dest_pointer_next = dest_pointer;
    end else if (descending) begin
      dest_pointer_next = dest_pointer - step;
    end else begin
      dest_pointer_next = dest_pointer + step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      column       <= '0;
      line         <= '0;
      dest_pointer <= '0;
      a_hold       <= 16'h0000;
      b_hold       <= 16'h0000;
    end else if (take_start) begin
      // A start abandons any running blit and rewinds.
      active       <= 1'b1;
      column       <= '0;
      line         <= '0;
      dest_pointer <= dest_start;
      a_hold       <= 16'h0000;
      b_hold       <= 16'h0000;
    end else if (take_data) begin
      dest_pointer <= dest_pointer_next;
      if (last_col) begin
        column <= '0;
        a_hold <= 16'h0000;
        b_hold <= 16'h0000;
        if (last_line) begin
          line   <= '0;
          active <= 1'b0;
        end else begin
          line <= line_inc[LINE_BITS-1:0];
        end
      end else begin
        column <= column_inc[COL_BITS-1:0];
        a_hold <= a_new;
        b_hold <= b_new;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (take_data) begin
      dst_valid <= 1'b1;
    end else if (dst_ready) begin
      dst_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_data) begin
      dst_word.d_word    <= d_word;
      dst_word.d_address <= dest_pointer;
      dst_word.d_write   <= use_d;
      dst_word.line_end  <= last_col;
      dst_word.blit_done <= last_col && last_line;
    end
  end

  // The last word of the blit leaves the block idle.
  assert property (@(posedge clk) disable iff (rst)
    (take_data && last_col && last_line) |=> !active)
    else $error("blit still active after its last word");

  // A start rewinds the position and loads the pointer from dest_start.
  assert property (@(posedge clk) disable iff (rst)
    take_start |=> (active && column == '0 && line == '0 && a_hold == 16'h0000
                    && dest_pointer == $past(dest_start)))
    else $error("start did not rewind the blit");

  // Data words taken while idle change nothing and produce no result.
  assert property (@(posedge clk) disable iff (rst)
    (src_take && src_word.operation == OP_WORD && !active)
      |=> ($stable(dest_pointer) && $stable(column) && $stable(line) && !$rose(dst_valid)))
    else $error("data word while idle changed state");

  // With D disabled the destination pointer does not move.
  assert property (@(posedge clk) disable iff (rst)
    (take_data && !use_d) |=> $stable(dest_pointer))
    else $error("pointer moved with channel D disabled");

  // A result word carries the pointer value held when its source word came in.
  assert property (@(posedge clk) disable iff (rst)
    take_data |=> (dst_valid && dst_word.d_address == $past(dest_pointer)))
    else $error("result address does not match destination pointer");

endmodule
